@@ sv/projection_jacobian_camera_macros.svh @@
// assertion macros used by the projection jacobian checker
`ifndef PROJECTION_JACOBIAN_CAMERA_MACROS_SVH
`define PROJECTION_JACOBIAN_CAMERA_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PJC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("projection jacobian check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PJC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("projection jacobian check failed");

`endif

@@ sv/pjc_pkg.sv @@
// shared types and constants of the projection jacobian block
`timescale 1ns / 1ps

package pjc_pkg;

    localparam int NUM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ENTRY_W    = 32;
    localparam int NUM_COORDS = 4;
    localparam int NUM_LANES  = 8;

    // register indexes of the camera matrix
    localparam logic [CFG_IDX_W-1:0] REG_R0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2_C23 = 3'd5;

    // lanes 0..3 are the near quotients, lanes 4..7 the depth quotients
    typedef struct packed {
        logic                 row_index;
        logic                 set_done;
        logic                 zero_depth;
        logic [NUM_LANES-1:0] neg;
    } pjc_tag_t;

endpackage

@@ sv/projection_jacobian_camera.sv @@
// top level of the camera projection jacobian block
// One homogeneous point enters per transaction and leaves as two result
// transactions, the u/w row first and the v/w row second, so the block takes
// a new point while the previous one issues its second row and delivers one
// row per cycle, with no bubbles while both sides keep up. A row passes
// through the point hold stage, the matrix product stage, the round and
// saturate stage, the magnitude and square stage, then a divider of
// VALUE_WIDTH+1 stages, the first splitting the dividend and each later one
// settling one quotient bit, in eight lanes at once (four X/w, four X*u/w^2
// or X*v/w^2), and finally the output register. The output register is
// backed by a one-entry skid buffer, so the pipeline keeps moving after the
// consumer stalls until the skid buffer fills; the whole pipeline then
// holds until the skid buffer drains. The camera matrix sits in
// six 64-bit registers written through the configuration channel, which is
// always ready; an index beyond the sixth register is dropped. Configuration
// must only change while no point is in flight. Quotients truncate toward
// zero and saturate; a projected w of zero gives zeroed entries and raises
// zero_depth on both rows.
`timescale 1ns / 1ps

module projection_jacobian_camera #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pjc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pjc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [VALUE_WIDTH-1:0]      point_x,
    input  logic signed [VALUE_WIDTH-1:0]      point_y,
    input  logic signed [VALUE_WIDTH-1:0]      point_z,
    input  logic signed [VALUE_WIDTH-1:0]      point_h,
    input  logic                               final_point,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               row_index,
    output logic signed [VALUE_WIDTH-1:0]      d_near_0,
    output logic signed [VALUE_WIDTH-1:0]      d_near_1,
    output logic signed [VALUE_WIDTH-1:0]      d_near_2,
    output logic signed [VALUE_WIDTH-1:0]      d_near_3,
    output logic signed [VALUE_WIDTH-1:0]      d_depth_0,
    output logic signed [VALUE_WIDTH-1:0]      d_depth_1,
    output logic signed [VALUE_WIDTH-1:0]      d_depth_2,
    output logic signed [VALUE_WIDTH-1:0]      d_depth_3,
    output logic                               row_last,
    output logic                               set_done,
    output logic                               zero_depth
);
    import pjc_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int RW     = 2 * VALUE_WIDTH;
    localparam int PW     = ENTRY_W + VALUE_WIDTH;
    localparam int SW     = PW + 2;
    localparam int TW     = SW - FRAC_BITS;
    localparam int HALF_L = NUM_LANES / 2;

    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) << (FRAC_BITS - 1);
    localparam logic [VW-1:0]        MAX_POS  = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]        MIN_NEG  = {1'b1, {(VW-1){1'b0}}};

    // round half up, drop the fraction bits, clamp to the value range
    function automatic logic [VW-1:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        logic [TW-1:0]        t;
        r = (s + HALF_LSB) >>> FRAC_BITS;
        t = r[TW-1:0];
        if ((&t[TW-1:VW-1]) || (~|t[TW-1:VW-1]))
        begin
            return t[VW-1:0];
        end
        return t[TW-1] ? MIN_NEG : MAX_POS;
    endfunction

    function automatic logic [VW-1:0] magnitude(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    // camera matrix registers
    logic [CFG_DATA_W-1:0] cam_reg_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cam_reg_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cam_reg_reg[cfg_index] <= cfg_data;
        end
    end

    // global advance: the pipeline holds only while the skid buffer is full
    logic en;
    logic skid_valid_reg;
    assign en = !skid_valid_reg;

    // point hold stage, issues row 0 then row 1
    logic                           s0_valid_reg;
    logic                           s0_phase_reg;
    logic [NUM_COORDS-1:0][VW-1:0]  s0_pt_reg;
    logic                           s0_fin_reg;
    logic                           accept;

    assign in_ready = en && (!s0_valid_reg || s0_phase_reg);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_phase_reg <= 1'b0;
        end
        else if (en)
        begin
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
                s0_phase_reg <= 1'b0;
            end
            else if (s0_valid_reg)
            begin
                if (!s0_phase_reg)
                begin
                    s0_phase_reg <= 1'b1;
                end
                else
                begin
                    s0_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pt_reg  <= {point_h, point_z, point_y, point_x};
            s0_fin_reg <= final_point;
        end
    end

    // matrix product stage: row of the current token and the depth row
    logic [NUM_COORDS-1:0][ENTRY_W-1:0]   m_row;
    logic [NUM_COORDS-1:0][ENTRY_W-1:0]   m_dep;
    logic signed [PW-1:0]                 s1_prod_row_next [NUM_COORDS];
    logic signed [PW-1:0]                 s1_prod_dep_next [NUM_COORDS];

    logic                                 s1_valid_reg;
    logic                                 s1_row_reg;
    logic                                 s1_fin_reg;
    logic [NUM_COORDS-1:0][VW-1:0]        s1_pt_reg;
    logic signed [PW-1:0]                 s1_prod_row_reg [NUM_COORDS];
    logic signed [PW-1:0]                 s1_prod_dep_reg [NUM_COORDS];

    always_comb
    begin
        if (s0_phase_reg)
        begin
            m_row[0] = cam_reg_reg[REG_R1_C01][ENTRY_W-1:0];
            m_row[1] = cam_reg_reg[REG_R1_C01][2*ENTRY_W-1:ENTRY_W];
            m_row[2] = cam_reg_reg[REG_R1_C23][ENTRY_W-1:0];
            m_row[3] = cam_reg_reg[REG_R1_C23][2*ENTRY_W-1:ENTRY_W];
        end
        else
        begin
            m_row[0] = cam_reg_reg[REG_R0_C01][ENTRY_W-1:0];
            m_row[1] = cam_reg_reg[REG_R0_C01][2*ENTRY_W-1:ENTRY_W];
            m_row[2] = cam_reg_reg[REG_R0_C23][ENTRY_W-1:0];
            m_row[3] = cam_reg_reg[REG_R0_C23][2*ENTRY_W-1:ENTRY_W];
        end
        m_dep[0] = cam_reg_reg[REG_R2_C01][ENTRY_W-1:0];
        m_dep[1] = cam_reg_reg[REG_R2_C01][2*ENTRY_W-1:ENTRY_W];
        m_dep[2] = cam_reg_reg[REG_R2_C23][ENTRY_W-1:0];
        m_dep[3] = cam_reg_reg[REG_R2_C23][2*ENTRY_W-1:ENTRY_W];
        for (int c = 0; c < NUM_COORDS; c++)
        begin
            s1_prod_row_next[c] = $signed(m_row[c]) * $signed(s0_pt_reg[c]);
            s1_prod_dep_next[c] = $signed(m_dep[c]) * $signed(s0_pt_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_row_reg <= s0_phase_reg;
            s1_fin_reg <= s0_fin_reg;
            s1_pt_reg  <= s0_pt_reg;
            for (int c = 0; c < NUM_COORDS; c++)
            begin
                s1_prod_row_reg[c] <= s1_prod_row_next[c];
                s1_prod_dep_reg[c] <= s1_prod_dep_next[c];
            end
        end
    end

    // projection stage: sum, round and saturate u or v, and w
    logic signed [SW-1:0]           sum_row;
    logic signed [SW-1:0]           sum_dep;

    logic                           s2_valid_reg;
    logic                           s2_row_reg;
    logic                           s2_fin_reg;
    logic [NUM_COORDS-1:0][VW-1:0]  s2_pt_reg;
    logic [VW-1:0]                  s2_prj_reg;
    logic [VW-1:0]                  s2_w_reg;

    always_comb
    begin
        sum_row = '0;
        sum_dep = '0;
        for (int c = 0; c < NUM_COORDS; c++)
        begin
            sum_row = sum_row + SW'(s1_prod_row_reg[c]);
            sum_dep = sum_dep + SW'(s1_prod_dep_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_row_reg <= s1_row_reg;
            s2_fin_reg <= s1_fin_reg;
            s2_pt_reg  <= s1_pt_reg;
            s2_prj_reg <= round_sat(sum_row);
            s2_w_reg   <= round_sat(sum_dep);
        end
    end

    // magnitude stage: divider operands and signs
    logic [VW-1:0]                  w_mag;
    logic [VW-1:0]                  prj_mag;
    logic [NUM_LANES-1:0][RW-1:0]   s3_num_next;
    pjc_tag_t                       s3_tag_next;

    logic                           s3_valid_reg;
    logic [NUM_LANES-1:0][RW-1:0]   s3_num_reg;
    logic [RW-1:0]                  s3_den_near_reg;
    logic [RW-1:0]                  s3_den_depth_reg;
    pjc_tag_t                       s3_tag_reg;

    always_comb
    begin
        logic [VW-1:0] x_mag;
        logic          x_neg;
        w_mag   = magnitude(s2_w_reg);
        prj_mag = magnitude(s2_prj_reg);
        s3_tag_next.row_index  = s2_row_reg;
        s3_tag_next.set_done   = s2_row_reg && s2_fin_reg;
        s3_tag_next.zero_depth = (s2_w_reg == '0);
        for (int c = 0; c < NUM_COORDS; c++)
        begin
            x_mag = magnitude(s2_pt_reg[c]);
            x_neg = s2_pt_reg[c][VW-1];
            s3_num_next[c]          = RW'(x_mag);
            s3_num_next[c + HALF_L] = RW'(x_mag) * RW'(prj_mag);
            s3_tag_next.neg[c]          = x_neg ^ s2_w_reg[VW-1];
            s3_tag_next.neg[c + HALF_L] = !(x_neg ^ s2_prj_reg[VW-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_num_reg       <= s3_num_next;
            s3_den_near_reg  <= RW'(w_mag);
            s3_den_depth_reg <= RW'(w_mag) * RW'(w_mag);
            s3_tag_reg       <= s3_tag_next;
        end
    end

    // divider pipeline
    logic                               dv_valid;
    logic [NUM_LANES-1:0][VW-1:0]       dv_quot;
    logic [NUM_LANES-1:0]               dv_ovf;
    pjc_tag_t                           dv_tag;

    pjc_div_pipe #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den_near  (s3_den_near_reg),
        .den_depth (s3_den_depth_reg),
        .in_tag    (s3_tag_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_ovf   (dv_ovf),
        .out_tag   (dv_tag)
    );

    // sign and clamp each quotient, zero depth clears the row
    logic [NUM_LANES-1:0][VW-1:0] res_next;

    always_comb
    begin
        logic [VW-1:0] q;
        logic          big_pos;
        logic          big_neg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            q       = dv_quot[l];
            big_pos = dv_ovf[l] || q[VW-1];
            big_neg = dv_ovf[l] || (q[VW-1] && (|q[VW-2:0]));
            if (dv_tag.zero_depth)
            begin
                res_next[l] = '0;
            end
            else if (dv_tag.neg[l])
            begin
                res_next[l] = big_neg ? MIN_NEG : (~q + 1'b1);
            end
            else
            begin
                res_next[l] = big_pos ? MAX_POS : q;
            end
        end
    end

    // output register and skid buffer
    logic                          out_valid_reg;
    logic [NUM_LANES-1:0][VW-1:0]  out_res_reg;
    pjc_tag_t                      out_tag_reg;
    logic [NUM_LANES-1:0][VW-1:0]  skid_res_reg;
    pjc_tag_t                      skid_tag_reg;
    logic                          out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= dv_valid;
            end
        end
        else if (en && dv_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
                out_tag_reg <= skid_tag_reg;
            end
            else
            begin
                out_res_reg <= res_next;
                out_tag_reg <= dv_tag;
            end
        end
        else if (!skid_valid_reg)
        begin
            skid_res_reg <= res_next;
            skid_tag_reg <= dv_tag;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = out_tag_reg.row_index;
    assign row_last   = out_tag_reg.row_index;
    assign set_done   = out_tag_reg.set_done;
    assign zero_depth = out_tag_reg.zero_depth;
    assign d_near_0   = out_res_reg[0];
    assign d_near_1   = out_res_reg[1];
    assign d_near_2   = out_res_reg[2];
    assign d_near_3   = out_res_reg[3];
    assign d_depth_0  = out_res_reg[HALF_L];
    assign d_depth_1  = out_res_reg[HALF_L + 1];
    assign d_depth_2  = out_res_reg[HALF_L + 2];
    assign d_depth_3  = out_res_reg[HALF_L + 3];

endmodule

@@ sv/pjc_div_pipe.sv @@
// pipelined restoring divider, eight lanes, one quotient bit per stage after the first
`timescale 1ns / 1ps

module pjc_div_pipe #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic                                                in_valid,
    input  logic [pjc_pkg::NUM_LANES-1:0][2*VALUE_WIDTH-1:0]    num,
    input  logic [2*VALUE_WIDTH-1:0]                            den_near,
    input  logic [2*VALUE_WIDTH-1:0]                            den_depth,
    input  pjc_pkg::pjc_tag_t                                   in_tag,
    output logic                                                out_valid,
    output logic [pjc_pkg::NUM_LANES-1:0][VALUE_WIDTH-1:0]      out_quot,
    output logic [pjc_pkg::NUM_LANES-1:0]                       out_ovf,
    output pjc_pkg::pjc_tag_t                                   out_tag
);
    import pjc_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int RW     = 2 * VALUE_WIDTH;
    localparam int AW     = RW + FRAC_BITS;
    localparam int STAGES = VALUE_WIDTH + 1;
    localparam int HALF_L = NUM_LANES / 2;

    logic [STAGES-1:0]     vld_reg;
    logic [RW-1:0]         rem_reg  [STAGES][NUM_LANES];
    logic [VW-1:0]         dq_reg   [STAGES][NUM_LANES];
    logic [NUM_LANES-1:0]  ovf_reg  [STAGES];
    logic [RW-1:0]         dn_reg   [STAGES];
    logic [RW-1:0]         dd_reg   [STAGES];
    pjc_tag_t              tag_reg  [STAGES];

    logic [RW-1:0]         rem_next [STAGES][NUM_LANES];
    logic [VW-1:0]         dq_next  [STAGES][NUM_LANES];
    logic [NUM_LANES-1:0]  ovf_next;

    // stage 0 splits the scaled dividend, later stages each settle one bit
    always_comb
    begin
        logic [AW-1:0] a;
        logic [AW-1:0] a_sh;
        logic [RW-1:0] d;
        logic [RW:0]   trial;
        logic          qbit;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            d           = (l < HALF_L) ? den_near : den_depth;
            a           = {num[l], {FRAC_BITS{1'b0}}};
            a_sh        = a >> VW;
            ovf_next[l] = (a_sh >= AW'(d));
            rem_next[0][l] = a_sh[RW-1:0];
            dq_next[0][l]  = a[VW-1:0];
        end
        for (int s = 1; s < STAGES; s++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                d     = (l < HALF_L) ? dn_reg[s-1] : dd_reg[s-1];
                trial = {rem_reg[s-1][l], dq_reg[s-1][l][VW-1]};
                qbit  = (trial >= {1'b0, d});
                if (qbit)
                begin
                    trial = trial - {1'b0, d};
                end
                rem_next[s][l] = trial[RW-1:0];
                dq_next[s][l]  = {dq_reg[s-1][l][VW-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    dq_reg[s][l]  <= dq_next[s][l];
                end
            end
            ovf_reg[0] <= ovf_next;
            dn_reg[0]  <= den_near;
            dd_reg[0]  <= den_depth;
            tag_reg[0] <= in_tag;
            for (int s = 1; s < STAGES; s++)
            begin
                ovf_reg[s] <= ovf_reg[s-1];
                dn_reg[s]  <= dn_reg[s-1];
                dd_reg[s]  <= dd_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_ovf   = ovf_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_quot[l] = dq_reg[STAGES-1][l];
        end
    end

endmodule

@@ sv/pjc_checker.sv @@
// port-level checks of the projection jacobian block and their binding
`timescale 1ns / 1ps
`include "projection_jacobian_camera_macros.svh"

module pjc_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          row_index,
    input logic                          row_last,
    input logic                          set_done,
    input logic                          zero_depth,
    input logic signed [VALUE_WIDTH-1:0] d_near_0,
    input logic signed [VALUE_WIDTH-1:0] d_near_1,
    input logic signed [VALUE_WIDTH-1:0] d_near_2,
    input logic signed [VALUE_WIDTH-1:0] d_near_3,
    input logic signed [VALUE_WIDTH-1:0] d_depth_0,
    input logic signed [VALUE_WIDTH-1:0] d_depth_1,
    input logic signed [VALUE_WIDTH-1:0] d_depth_2,
    input logic signed [VALUE_WIDTH-1:0] d_depth_3
);

    // a stalled row keeps its transaction
    `PJC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(d_near_0) && $stable(d_depth_0))

    // zero depth rows carry only zero entries
    `PJC_ASSERT_IMP(a_zero_rows, out_valid && zero_depth, d_near_0 == '0 && d_near_1 == '0 && d_near_2 == '0 && d_near_3 == '0 && d_depth_0 == '0 && d_depth_1 == '0 && d_depth_2 == '0 && d_depth_3 == '0)

    // row flags agree, set end only on the second row
    `PJC_ASSERT_IMP(a_row_flags, out_valid, (row_last == row_index) && (!set_done || row_last))

    // each point holds the input for its second row
    `PJC_ASSERT_NXT(a_point_rate, in_valid && in_ready, !in_ready)

endmodule

bind projection_jacobian_camera pjc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pjc_checker (.*);

@@ test/tb_projection_jacobian_camera.sv @@
// testbench for the camera projection jacobian block: directed and random points
`timescale 1ns / 1ps

module tb_projection_jacobian_camera;
    import pjc_pkg::*;

    // indexes past the camera matrix, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int  FRAC       = 16;
    localparam int  DRAIN_WAIT = 60;    // a bit more than the pipeline depth
    localparam int  STALL_LIMIT = 4000; // cycles with no transaction at all
    localparam int  HOLD_OFF   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] point_x = '0, point_y = '0, point_z = '0, point_h = '0;
    logic final_point = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic row_index, row_last, set_done, zero_depth;
    logic signed [31:0] d_near_0, d_near_1, d_near_2, d_near_3;
    logic signed [31:0] d_depth_0, d_depth_1, d_depth_2, d_depth_3;

    projection_jacobian_camera u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .point_h(point_h),
        .final_point(final_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .row_index(row_index),
        .d_near_0(d_near_0), .d_near_1(d_near_1), .d_near_2(d_near_2), .d_near_3(d_near_3),
        .d_depth_0(d_depth_0), .d_depth_1(d_depth_1),
        .d_depth_2(d_depth_2), .d_depth_3(d_depth_3),
        .row_last(row_last), .set_done(set_done), .zero_depth(zero_depth)
    );

    always #5 clk = ~clk;

    // one jacobian row as the block should deliver it
    typedef struct {
        logic               row;
        logic signed [31:0] near_val [4];
        logic signed [31:0] depth_val [4];
        logic               last;
        logic               done;
        logic               zero;
    } jac_row_t;

    jac_row_t    rows_pending [$];
    logic [63:0] cam_matrix [NUM_REGS];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    // ---------------------------------------------------------------
    // predictor of the block, exact arithmetic on wide vectors
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sh7fffffff)
            return 32'sh7fffffff;
        if (v < -128'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [127:0] abs_wide(logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // entry of matrix row r, column c, as a signed q16.16 value
    function automatic logic signed [31:0] cam_entry(int r, int c);
        logic [63:0] reg_val;
        reg_val = cam_matrix[r * 2 + c / 2];
        return (c % 2) ? reg_val[63:32] : reg_val[31:0];
    endfunction

    // one row of the projection, round half up, then clamp
    function automatic logic signed [31:0] project_coord(int r, logic signed [31:0] pt [4]);
        logic signed [127:0] acc;
        logic signed [127:0] e;
        logic signed [127:0] p;
        acc = '0;
        for (int c = 0; c < 4; c++) begin
            e = cam_entry(r, c);
            p = pt[c];
            acc = acc + e * p;
        end
        acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        return clamp32(acc);
    endfunction

    // truncated quotient with the fraction bits, clamped per sign
    function automatic logic signed [31:0] quotient(logic [127:0] num, logic [127:0] den,
                                                   bit neg);
        logic [127:0] q;
        logic [127:0] nq;
        if (den == 0)
            return '0;
        q = (num << FRAC) / den;
        if (neg) begin
            if (q > 128'h80000000)
                q = 128'h80000000;
            nq = ~q + 128'd1;
            return nq[31:0];
        end
        if (q > 128'h7fffffff)
            q = 128'h7fffffff;
        return q[31:0];
    endfunction

    // queue both rows that one accepted point should produce
    task automatic predict_rows(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic signed [31:0] ph, logic fin);
        logic signed [31:0] pt [4];
        logic signed [31:0] uvw [3];
        logic [127:0] w_mag;
        logic [127:0] w_sq;
        jac_row_t rw;
        bit w_neg;
        bit x_neg;
        bit p_neg;
        pt[0] = px; pt[1] = py; pt[2] = pz; pt[3] = ph;
        for (int r = 0; r < 3; r++)
            uvw[r] = project_coord(r, pt);
        w_neg = uvw[2] < 0;
        w_mag = abs_wide(uvw[2]);
        w_sq = w_mag * w_mag;
        for (int r = 0; r < 2; r++) begin
            rw.row = r[0];
            rw.last = r[0];
            rw.done = (r == 1) ? fin : 1'b0;
            rw.zero = (uvw[2] == 0);
            for (int j = 0; j < 4; j++) begin
                x_neg = pt[j] < 0;
                p_neg = uvw[r] < 0;
                if (rw.zero) begin
                    rw.near_val[j] = '0;
                    rw.depth_val[j] = '0;
                end
                else begin
                    rw.near_val[j] = quotient(abs_wide(pt[j]), w_mag, x_neg != w_neg);
                    // depth term carries a minus, so equal signs give a negative value
                    rw.depth_val[j] = quotient(abs_wide(pt[j]) * abs_wide(uvw[r]), w_sq,
                                               x_neg == p_neg);
                end
            end
            rows_pending.push_back(rw);
        end
    endtask

    // ---------------------------------------------------------------
    // result checking and watchdog, sampled at the rising edge
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk) begin
        jac_row_t want;
        logic signed [31:0] got_near [4];
        logic signed [31:0] got_depth [4];
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (rows_pending.size() == 0) begin
                    $display("unexpected row transaction at %0t", $realtime);
                    fail_count++;
                end
                else begin
                    want = rows_pending.pop_front();
                    got_near = '{d_near_0, d_near_1, d_near_2, d_near_3};
                    got_depth = '{d_depth_0, d_depth_1, d_depth_2, d_depth_3};
                    if (row_index !== want.row)
                        report_mismatch("row_index", row_index, want.row);
                    for (int j = 0; j < 4; j++) begin
                        if (got_near[j] !== want.near_val[j])
                            report_mismatch($sformatf("d_near_%0d", j), got_near[j],
                                            want.near_val[j]);
                        if (got_depth[j] !== want.depth_val[j])
                            report_mismatch($sformatf("d_depth_%0d", j), got_depth[j],
                                            want.depth_val[j]);
                    end
                    if (row_last !== want.last)
                        report_mismatch("row_last", row_last, want.last);
                    if (set_done !== want.done)
                        report_mismatch("set_done", set_done, want.done);
                    if (zero_depth !== want.zero)
                        report_mismatch("zero_depth", zero_depth, want.zero);
                end
            end
        end
    end

    // receiver: random stall pattern, or a long hold-off on request
    always @(negedge clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_OFF;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (stalls_on)
            out_ready = ($urandom_range(0, 3) != 0);
        else
            out_ready = 1'b1;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // one point transaction, valid is left high for a following send
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic signed [31:0] ph, logic fin);
        @(negedge clk);
        in_valid = 1'b1;
        point_x = px; point_y = py; point_z = pz; point_h = ph;
        final_point = fin;
        do
            @(posedge clk);
        while (!in_ready);
        predict_rows(px, py, pz, ph, fin);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // all rows back, then let the pipeline settle before touching registers
    task automatic wait_drained();
        sender_gap(1);
        wait (rows_pending.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            cam_matrix[idx] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_camera(logic [63:0] m [NUM_REGS]);
        write_reg(REG_R0_C01, m[0]);
        write_reg(REG_R0_C23, m[1]);
        write_reg(REG_R1_C01, m[2]);
        write_reg(REG_R1_C23, m[3]);
        write_reg(REG_R2_C01, m[4]);
        write_reg(REG_R2_C23, m[5]);
    endtask

    // mostly moderate values so quotients stay in range, some extremes
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return '0;
            4: return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
            default: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
        endcase
    endfunction

    task automatic random_camera();
        logic [63:0] m [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = {rand_value(), rand_value()};
        load_camera(m);
    endtask

    // points in random bursts, with random gaps between them while gaps_on is set
    task automatic send_random_points(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++) begin
                if ($urandom_range(0, 19) == 0)
                    send_point('0, '0, '0, '0, $urandom_range(0, 1));
                else
                    send_point(rand_value(), rand_value(), rand_value(), rand_value(),
                               ($urandom_range(0, 7) == 0));
                sent++;
            end
            if (gaps_on && $urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 8));
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // identity-like camera, spare index writes, corner values of the point fields, w of zero
    task automatic test_directed();
        logic [63:0] ident [NUM_REGS];
        ident = '{64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
                  64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
                  64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000};
        load_camera(ident);
        write_reg(REG_SPARE_6, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_SPARE_7, 64'h1234_5678_9abc_def0);
        send_point(32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00010000, 1'b0);
        send_point(32'sh00030000, -32'sh00010000, -32'sh00020000, 32'sh00010000, 1'b1);
        send_point('0, '0, '0, '0, 1'b1);                                   // w zero
        send_point(32'sh00050000, 32'sh00050000, '0, '0, 1'b0);             // w zero
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        send_point(32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'sh7fffffff, 1'b0);
        send_point(32'sh00000001, 32'sh00000001, 32'sh00000001, 32'sh00000001, 1'b0);
        send_point(32'sh00000001, -32'sh00000001, 32'sh7fffffff, 32'sh00000001, 1'b1);
        sender_gap(3);
        send_point(-32'sh00008000, 32'sh00008000, 32'sh00100000, -32'sh00020000, 1'b0);
        send_point(32'sh00000000, 32'sh80000000, -32'sh00000001, 32'sh00000002, 1'b1);
        send_point($urandom, $urandom, $urandom, $urandom, 1'b0);
        wait_drained();
    endtask

    // moderate random camera and points with both sides idling
    task automatic test_random_moderate();
        random_camera();
        send_random_points(200);
        wait_drained();
    endtask

    // extreme cameras: all zero, all most positive, all most negative
    task automatic test_extreme_cameras();
        logic [63:0] m [NUM_REGS];
        m = '{default: 64'h0};
        load_camera(m);
        send_random_points(20);
        wait_drained();
        m = '{default: 64'h7fffffff_7fffffff};
        load_camera(m);
        send_random_points(25);
        wait_drained();
        m = '{default: 64'h80000000_80000000};
        load_camera(m);
        send_random_points(25);
        wait_drained();
    endtask

    // receiver holds off long while the sender keeps offering points
    task automatic test_backpressure();
        random_camera();
        hold_req = 1'b1;
        gaps_on = 1'b0;
        send_random_points(80);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // fully random camera words, a stretch with no idling, then idling again, then a new random camera
    task automatic test_random_full();
        logic [63:0] m [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = {$urandom, $urandom};
        load_camera(m);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_random_points(60);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        send_random_points(60);
        wait_drained();
        random_camera();
        send_random_points(100);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++)
            cam_matrix[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_moderate();
        test_extreme_cameras();
        test_backpressure();
        test_random_full();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
